// ----- hdl/bta_pkg.sv -----
`timescale 1ns / 1ps

package bta_pkg;

  // Field widths of one beacon record and of one result.
  localparam int unsigned ADDR_W    = 48;
  localparam int unsigned TIME_W    = 48;
  localparam int unsigned PKT_W     = 16;
  localparam int unsigned KEY_W     = 16;
  localparam int unsigned IV_W      = 16;
  localparam int unsigned VERDICT_W = 3;
  localparam int unsigned IDX_OUT_W = 3;
  localparam int unsigned DEV_W     = 32;

  // Verdict codes of one result.
  localparam logic [VERDICT_W-1:0] V_REF   = 3'd0;
  localparam logic [VERDICT_W-1:0] V_AUTH  = 3'd1;
  localparam logic [VERDICT_W-1:0] V_REJ   = 3'd2;
  localparam logic [VERDICT_W-1:0] V_STALE = 3'd3;
  localparam logic [VERDICT_W-1:0] V_FULL  = 3'd4;

  // Radix-16 divider by a fixed divisor.
  localparam int unsigned DIVISOR     = 1000;
  localparam int unsigned DIV_NUM_W   = 48;
  localparam int unsigned DIV_DIGIT_W = 4;
  localparam int unsigned DIV_REM_W   = 10;
  localparam int unsigned DIV_PART_W  = DIV_REM_W + DIV_DIGIT_W;
  localparam int unsigned DIV_STEP_W  = 4;
  localparam int unsigned MS_STEPS    = DIV_NUM_W / DIV_DIGIT_W;
  localparam int unsigned WIN_NUM_W   = 28;
  localparam int unsigned WIN_STEPS   = WIN_NUM_W / DIV_DIGIT_W;

  typedef struct packed {
    logic                  start;
    logic [DIV_STEP_W-1:0] steps;
  } div_req_t;

  // One word of the sender memory.
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [TIME_W-1:0] tstamp;
    logic [PKT_W-1:0]  pkt;
    logic [KEY_W-1:0]  key;
  } entry_t;

  // Reference state of one entry as seen by the sequencer.
  typedef struct packed {
    logic              vld;
    logic [TIME_W-1:0] tstamp;
    logic [PKT_W-1:0]  pkt;
    logic [KEY_W-1:0]  key;
  } ref_t;

endpackage

// ----- hdl/bta_ram.sv -----
`timescale 1ns / 1ps

module bta_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/bta_div.sv -----
`timescale 1ns / 1ps

module bta_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bta_pkg::div_req_t             req_i,
  input  logic [bta_pkg::DIV_NUM_W-1:0] num_i,
  output logic                          idle_o,
  output logic [bta_pkg::DIV_NUM_W-1:0] quot_o
);
  import bta_pkg::*;

  logic [DIV_NUM_W-1:0]   num_q, num_d;
  logic [DIV_NUM_W-1:0]   quot_q, quot_d;
  logic [DIV_REM_W-1:0]   rem_q, rem_d;
  logic [DIV_STEP_W-1:0]  cnt_q, cnt_d;
  logic [DIV_PART_W-1:0]  part;
  logic [DIV_DIGIT_W-1:0] digit;

  // One quotient digit per cycle: the partial remainder never reaches sixteen times the divisor.
  always_comb begin
    part  = {rem_q, num_q[DIV_NUM_W-1 -: DIV_DIGIT_W]};
    digit = '0;
    for (int k = 1; k < (1 << DIV_DIGIT_W); k++) begin
      if (part >= DIV_PART_W'(k * DIVISOR)) begin
        digit = digit + DIV_DIGIT_W'(1);
      end
    end
  end

  always_comb begin
    num_d  = num_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    if (req_i.start) begin
      num_d  = num_i;
      quot_d = '0;
      rem_d  = '0;
      cnt_d  = req_i.steps;
    end else if (cnt_q != '0) begin
      num_d  = num_q << DIV_DIGIT_W;
      quot_d = {quot_q[DIV_NUM_W-DIV_DIGIT_W-1:0], digit};
      rem_d  = DIV_REM_W'(part - DIV_PART_W'(digit * DIVISOR));
      cnt_d  = cnt_q - DIV_STEP_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    quot_q <= quot_d;
    rem_q  <= rem_d;
  end

  assign idle_o = (cnt_q == '0);
  assign quot_o = quot_q;

endmodule

// ----- hdl/beacon_timing_authorizer_unit.sv -----
`timescale 1ns / 1ps
// Busy stays high while the sequencer scans the table entries (1 to SENDER_ENTRIES of them)
// and, when the timing check runs, through the shared datapath and both divisions; the result
// strobe follows in the cycle after the last busy cycle.
// Throughput: one transaction at a time; the entry scan and the shared divider set how long busy stays high.
// Reset: asynchronous, active low; clears the sequencer, the entry flags and the strobe.
// The receiver cannot stall: each result is shown for exactly one cycle.

module beacon_timing_authorizer_unit #(
  parameter int unsigned SENDER_ENTRIES = 8
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [bta_pkg::ADDR_W-1:0]           sender_address_i,
  input  logic [bta_pkg::TIME_W-1:0]           capture_time_us_i,
  input  logic [bta_pkg::PKT_W-1:0]            packet_number_i,
  input  logic [bta_pkg::KEY_W-1:0]            key_identifier_i,
  input  logic [bta_pkg::IV_W-1:0]             advertising_interval_ms_i,
  output logic                                 result_valid_o,
  output logic [bta_pkg::VERDICT_W-1:0]        verdict_o,
  output logic [bta_pkg::IDX_OUT_W-1:0]        entry_index_o,
  output logic [bta_pkg::PKT_W-1:0]            released_packet_number_o,
  output logic signed [bta_pkg::DEV_W-1:0]     deviation_ms_o
);
  import bta_pkg::*;

  localparam int unsigned IW    = (SENDER_ENTRIES > 1) ? $clog2(SENDER_ENTRIES) : 1;
  localparam int unsigned ACC_W = TIME_W + 2;
  localparam int unsigned MUL_W = 2 * IV_W;
  localparam int unsigned HI_W  = ACC_W - DEV_W + 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(SENDER_ENTRIES - 1);

  // Sequencer states.
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SCAN  = 4'd1;
  localparam logic [3:0] S_EVAL  = 4'd2;
  localparam logic [3:0] S_ELAP  = 4'd3;
  localparam logic [3:0] S_ABS   = 4'd4;
  localparam logic [3:0] S_DLD1  = 4'd5;
  localparam logic [3:0] S_DIV1  = 4'd6;
  localparam logic [3:0] S_MS    = 4'd7;
  localparam logic [3:0] S_DIFF  = 4'd8;
  localparam logic [3:0] S_DLD2  = 4'd9;
  localparam logic [3:0] S_DIV2  = 4'd10;
  localparam logic [3:0] S_JUDGE = 4'd11;

  // Tolerance tiers. The window is floor(interval * factor / 1000), which matches each
  // percentage tier exactly, so the same divider serves both divisions.
  localparam logic [IV_W-1:0] TIER_3000 = 16'd3000;
  localparam logic [IV_W-1:0] TIER_1000 = 16'd1000;
  localparam logic [IV_W-1:0] TIER_500  = 16'd500;
  localparam logic [IV_W-1:0] TIER_200  = 16'd200;
  localparam logic [IV_W-1:0] FACT_5    = 16'd50;
  localparam logic [IV_W-1:0] FACT_10   = 16'd100;
  localparam logic [IV_W-1:0] FACT_15   = 16'd150;
  localparam logic [IV_W-1:0] FACT_20   = 16'd200;
  localparam logic [IV_W-1:0] FACT_30   = 16'd300;

  logic [3:0] state_q, state_d;

  // Captured transaction.
  logic [ADDR_W-1:0] addr_q;
  logic [TIME_W-1:0] cap_q;
  logic [PKT_W-1:0]  pkt_q;
  logic [KEY_W-1:0]  key_q;
  logic [IV_W-1:0]   iv_q;

  // Scan bookkeeping.
  logic [IW-1:0] idx_q, idx_d;
  logic [IW-1:0] ent_q, ent_d;
  logic [IW-1:0] free_idx_q, free_idx_d;
  logic          free_found_q, free_found_d;
  ref_t          free_ref_q, free_ref_d;
  ref_t          ref_q, ref_d;

  // Per-entry flags. An entry whose occupied bit is clear reads as a free (zero) address,
  // and an entry whose reference bit is clear reads as an all-zero reference.
  logic [SENDER_ENTRIES-1:0] occ_q, occ_d;
  logic [SENDER_ENTRIES-1:0] refv_q, refv_d;

  // Shared datapath: one adder/subtractor, one 16x16 multiplier and the divider.
  logic [ACC_W-1:0] acc_q, acc_d;
  logic             neg_q, neg_d;
  logic [MUL_W-1:0] prod_q, prod_d;
  logic [DEV_W-1:0] dsat_q, dsat_d;
  logic [ACC_W-1:0] alu_a, alu_b, alu_y;
  logic             alu_sub;
  logic [IV_W-1:0]  mul_a;
  logic [MUL_W-1:0] mul_y;
  logic [IV_W-1:0]  win_factor;
  logic [HI_W-1:0]  alu_hi;

  div_req_t              div_req;
  logic [DIV_NUM_W-1:0]  div_num;
  logic                  div_idle;
  logic [DIV_NUM_W-1:0]  div_quot;

  // Memory interface.
  logic          ram_we;
  entry_t        ram_wdata;
  logic [IW-1:0] ram_raddr;
  entry_t        ram_rdata;

  // Scan view of the entry whose word sits on the memory output.
  logic [ADDR_W-1:0] cur_addr;
  logic              cur_free;
  ref_t              cur_ref;

  logic              key_hit;
  logic signed [DEV_W-1:0] win_pos, win_neg;
  entry_t            new_word, old_word;

  // Result registers.
  logic                 res_vld_q, res_vld_d;
  logic [VERDICT_W-1:0] verdict_q, verdict_d;
  logic [IDX_OUT_W-1:0] ent_out_q, ent_out_d;
  logic [PKT_W-1:0]     rel_q, rel_d;
  logic [DEV_W-1:0]     dev_q, dev_d;

  assign busy = (state_q != S_IDLE);

  bta_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (SENDER_ENTRIES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ent_q),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  bta_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .num_i  (div_num),
    .idle_o (div_idle),
    .quot_o (div_quot)
  );

  // The scan reads one entry per cycle: while the word of entry idx_q is on the memory
  // output, the read of the next entry is already issued. The accepting cycle reads entry 0.
  assign ram_raddr = (state_q == S_SCAN && idx_q != LAST_IDX) ? idx_q + IW'(1) : '0;

  always_comb begin
    cur_addr       = occ_q[idx_q] ? ram_rdata.addr : '0;
    cur_free       = (cur_addr == '0);
    cur_ref.vld    = refv_q[idx_q];
    cur_ref.tstamp = refv_q[idx_q] ? ram_rdata.tstamp : '0;
    cur_ref.pkt    = refv_q[idx_q] ? ram_rdata.pkt : '0;
    cur_ref.key    = refv_q[idx_q] ? ram_rdata.key : '0;
  end

  assign key_hit  = ref_q.vld && (ref_q.key == key_q);
  assign new_word = '{addr: addr_q, tstamp: cap_q, pkt: pkt_q, key: key_q};
  assign old_word = '{addr: addr_q, tstamp: ref_q.tstamp, pkt: ref_q.pkt, key: ref_q.key};

  always_comb begin
    priority if (iv_q >= TIER_3000) begin
      win_factor = FACT_5;
    end else if (iv_q >= TIER_1000) begin
      win_factor = FACT_10;
    end else if (iv_q > TIER_500) begin
      win_factor = FACT_15;
    end else if (iv_q > TIER_200) begin
      win_factor = FACT_20;
    end else begin
      win_factor = FACT_30;
    end
  end

  // Operand selection for the shared adder and multiplier.
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    mul_a   = '0;
    unique case (state_q)
      S_ELAP: begin
        // Measured elapsed microseconds, a plain signed difference.
        alu_a   = ACC_W'(cap_q);
        alu_b   = ACC_W'(ref_q.tstamp);
        alu_sub = 1'b1;
        mul_a   = pkt_q - ref_q.pkt;
      end
      S_ABS: begin
        alu_a   = acc_q[ACC_W-1] ? '0 : acc_q;
        alu_b   = acc_q[ACC_W-1] ? acc_q : '0;
        alu_sub = acc_q[ACC_W-1];
      end
      S_MS: begin
        // Restore the sign, so the division truncates toward zero.
        alu_a   = neg_q ? '0 : ACC_W'(div_quot);
        alu_b   = neg_q ? ACC_W'(div_quot) : '0;
        alu_sub = neg_q;
      end
      S_DIFF: begin
        alu_a   = ACC_W'(prod_q);
        alu_b   = acc_q;
        alu_sub = 1'b1;
        mul_a   = win_factor;
      end
      default: begin
        alu_sub = 1'b0;
      end
    endcase
  end

  assign alu_y  = alu_a + (alu_sub ? ~alu_b : alu_b) + ACC_W'(alu_sub);
  assign mul_y  = MUL_W'(mul_a) * MUL_W'(iv_q);
  assign alu_hi = alu_y[ACC_W-1:DEV_W-1];

  assign win_pos = $signed({{(DEV_W-IV_W){1'b0}}, div_quot[IV_W-1:0]});
  assign win_neg = -win_pos;

  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    ent_d        = ent_q;
    free_idx_d   = free_idx_q;
    free_found_d = free_found_q;
    free_ref_d   = free_ref_q;
    ref_d        = ref_q;
    occ_d        = occ_q;
    refv_d       = refv_q;
    acc_d        = acc_q;
    neg_d        = neg_q;
    prod_d       = prod_q;
    dsat_d       = dsat_q;
    res_vld_d    = 1'b0;
    verdict_d    = verdict_q;
    ent_out_d    = ent_out_q;
    rel_d        = rel_q;
    dev_d        = dev_q;
    ram_we       = 1'b0;
    ram_wdata    = new_word;
    div_req      = '0;
    div_num      = '0;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          state_d      = S_SCAN;
          idx_d        = '0;
          free_found_d = 1'b0;
        end
      end

      S_SCAN: begin
        if (cur_addr == addr_q) begin
          // A zero address lands here on the first free entry.
          ent_d   = idx_q;
          ref_d   = cur_ref;
          state_d = S_EVAL;
        end else begin
          if (cur_free) begin
            free_idx_d   = idx_q;
            free_ref_d   = cur_ref;
            free_found_d = 1'b1;
          end
          if (idx_q == LAST_IDX) begin
            // The highest free entry is taken for a new sender.
            if (cur_free) begin
              ent_d   = idx_q;
              ref_d   = cur_ref;
              state_d = S_EVAL;
            end else if (free_found_q) begin
              ent_d   = free_idx_q;
              ref_d   = free_ref_q;
              state_d = S_EVAL;
            end else begin
              res_vld_d = 1'b1;
              verdict_d = V_FULL;
              ent_out_d = '0;
              rel_d     = '0;
              dev_d     = '0;
              state_d   = S_IDLE;
            end
          end else begin
            idx_d = idx_q + IW'(1);
          end
        end
      end

      S_EVAL: begin
        if (key_hit && pkt_q <= ref_q.pkt) begin
          // Stale record: only a newly allocated address is recorded.
          ram_we    = 1'b1;
          ram_wdata = old_word;
          if (addr_q != '0) begin
            occ_d[ent_q] = 1'b1;
          end
          res_vld_d = 1'b1;
          verdict_d = V_STALE;
          ent_out_d = IDX_OUT_W'(ent_q);
          rel_d     = '0;
          dev_d     = '0;
          state_d   = S_IDLE;
        end else if (key_hit) begin
          state_d = S_ELAP;
        end else begin
          ram_we        = 1'b1;
          ram_wdata     = new_word;
          refv_d[ent_q] = 1'b1;
          if (addr_q != '0) begin
            occ_d[ent_q] = 1'b1;
          end
          res_vld_d = 1'b1;
          verdict_d = V_REF;
          ent_out_d = IDX_OUT_W'(ent_q);
          rel_d     = '0;
          dev_d     = '0;
          state_d   = S_IDLE;
        end
      end

      S_ELAP: begin
        acc_d   = alu_y;
        prod_d  = mul_y;
        state_d = S_ABS;
      end

      S_ABS: begin
        neg_d   = acc_q[ACC_W-1];
        acc_d   = alu_y;
        state_d = S_DLD1;
      end

      S_DLD1: begin
        div_req.start = 1'b1;
        div_req.steps = DIV_STEP_W'(MS_STEPS);
        div_num       = acc_q[DIV_NUM_W-1:0];
        state_d       = S_DIV1;
      end

      S_DIV1: begin
        if (div_idle) begin
          state_d = S_MS;
        end
      end

      S_MS: begin
        acc_d   = alu_y;
        state_d = S_DIFF;
      end

      S_DIFF: begin
        // Expected minus measured, saturated to 32-bit signed.
        priority if (alu_hi == '0 || alu_hi == '1) begin
          dsat_d = alu_y[DEV_W-1:0];
        end else if (alu_y[ACC_W-1]) begin
          dsat_d = {1'b1, {(DEV_W-1){1'b0}}};
        end else begin
          dsat_d = {1'b0, {(DEV_W-1){1'b1}}};
        end
        prod_d  = mul_y;
        state_d = S_DLD2;
      end

      S_DLD2: begin
        div_req.start = 1'b1;
        div_req.steps = DIV_STEP_W'(WIN_STEPS);
        div_num       = {prod_q[WIN_NUM_W-1:0], {(DIV_NUM_W-WIN_NUM_W){1'b0}}};
        state_d       = S_DIV2;
      end

      S_DIV2: begin
        if (div_idle) begin
          state_d = S_JUDGE;
        end
      end

      S_JUDGE: begin
        ram_we        = 1'b1;
        ram_wdata     = new_word;
        refv_d[ent_q] = 1'b1;
        if (addr_q != '0) begin
          occ_d[ent_q] = 1'b1;
        end
        res_vld_d = 1'b1;
        verdict_d = ($signed(dsat_q) <= win_pos && $signed(dsat_q) >= win_neg) ? V_AUTH : V_REJ;
        ent_out_d = IDX_OUT_W'(ent_q);
        rel_d     = ref_q.pkt;
        dev_d     = dsat_q;
        state_d   = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      occ_q     <= '0;
      refv_q    <= '0;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      occ_q     <= occ_d;
      refv_q    <= refv_d;
      res_vld_q <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start) begin
      addr_q <= sender_address_i;
      cap_q  <= capture_time_us_i;
      pkt_q  <= packet_number_i;
      key_q  <= key_identifier_i;
      iv_q   <= advertising_interval_ms_i;
    end
    idx_q        <= idx_d;
    ent_q        <= ent_d;
    free_idx_q   <= free_idx_d;
    free_found_q <= free_found_d;
    free_ref_q   <= free_ref_d;
    ref_q        <= ref_d;
    acc_q        <= acc_d;
    neg_q        <= neg_d;
    prod_q       <= prod_d;
    dsat_q       <= dsat_d;
    verdict_q    <= verdict_d;
    ent_out_q    <= ent_out_d;
    rel_q        <= rel_d;
    dev_q        <= dev_d;
  end

  assign result_valid_o           = res_vld_q;
  assign verdict_o                = verdict_q;
  assign entry_index_o            = ent_out_q;
  assign released_packet_number_o = rel_q;
  assign deviation_ms_o           = $signed(dev_q);

`ifndef SYNTH
  // A result only ever closes a transaction that kept the block busy.
  a_result_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(busy))
    else $error("result strobe without a preceding busy cycle");

  // A full table reports no entry and no timing figures.
  a_full_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && verdict_o == V_FULL) |->
      (entry_index_o == '0 && released_packet_number_o == '0 && deviation_ms_o == '0))
    else $error("table full result carries nonzero fields");

  // Without a timing check the judged packet and deviation fields stay zero.
  a_untimed_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (verdict_o == V_REF || verdict_o == V_STALE)) |->
      (released_packet_number_o == '0 && deviation_ms_o == '0))
    else $error("untimed verdict carries timing fields");

  // The shared divider is never left running once the sequencer is back at rest.
  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy |-> div_idle)
    else $error("divider still running while the block is idle");
`endif

endmodule
